@@ hdl/fnvdh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fnvdh_pkg;

    localparam int TABLE_BITS_DEF = 10;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int HASH_W   = 64;
    localparam int VALUE_W  = 30;
    localparam int SLOT_W   = 10;
    localparam int ERR_W    = 2;

    localparam logic [HASH_W-1:0] FNV_BASIS   = 64'hcbf29ce484222325;
    // FNV prime is 2^40 + 0x1b3
    localparam logic [HASH_W-1:0] FNV_MULT_LO = 64'h00000000000001b3;
    localparam int                FNV_SHIFT   = 40;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 2'd0,
        ERR_UNKNOWN = 2'd1,
        ERR_FULL    = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_PROBE
    } state_t;

endpackage

`default_nettype wire

@@ hdl/fnv_double_hash_symbol_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Symbol bytes: one per cycle, no result; busy stays low between bytes.
// Table operation: the ISSUE state reads the first slot, then the PROBE state checks 1 to
// 2^TABLE_BITS slots, and the result strobe is registered from the last; the single-port table
// memory reads one slot per cycle. busy is high from acceptance until the result cycle.
// Reset: after rst_n releases, the used bits of all 2^TABLE_BITS slots are swept clear, one
// slot per cycle, with busy high. The receiver cannot stall a result.

module fnv_double_hash_symbol_table #(
    parameter int TABLE_BITS = fnvdh_pkg::TABLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [fnvdh_pkg::ACTION_W-1:0]     action,
    input  logic [fnvdh_pkg::BYTE_W-1:0]       symbol_byte,
    input  logic                               last_byte,
    input  logic [fnvdh_pkg::VALUE_W-1:0]      query_hash,
    output logic                               done,
    output logic [fnvdh_pkg::VALUE_W-1:0]      symbol_value,
    output logic [fnvdh_pkg::SLOT_W-1:0]       slot,
    output logic                               found,
    output logic [fnvdh_pkg::ERR_W-1:0]        error_code
);
    import fnvdh_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int ENTRY_W    = HASH_W + 1;
    localparam logic [TABLE_BITS-1:0] LAST_SLOT = TABLE_BITS'(TABLE_SIZE - 1);

    state_t state_reg, state_next;

    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [HASH_W-1:0]     key_reg, key_next;
    logic                  insert_reg, insert_next;
    logic [TABLE_BITS-1:0] pos_reg, pos_next;
    logic [TABLE_BITS-1:0] count_reg, count_next;
    logic [TABLE_BITS-1:0] clr_reg, clr_next;

    logic                  done_reg, done_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  found_reg, found_next;
    err_t                  err_reg, err_next;

    // table memory: {used, hash}
    logic [ENTRY_W-1:0]    mem [TABLE_SIZE];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_en;
    logic [TABLE_BITS-1:0] rd_addr;
    logic                  wr_en;
    logic [TABLE_BITS-1:0] wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    logic [HASH_W-1:0]     mix;
    logic [HASH_W-1:0]     hash_prod;
    logic [VALUE_W-1:0]    key_high;
    logic [TABLE_BITS-1:0] stride;
    logic                  slot_used;
    logic                  slot_hit;
    logic                  probe_last;
    logic                  probe_end;

    // FNV-1a step: xor the byte in, multiply by 2^40 + 0x1b3
    assign mix       = hash_reg ^ HASH_W'(symbol_byte);
    assign hash_prod = (mix << FNV_SHIFT) + (mix * FNV_MULT_LO);

    assign key_high = key_reg[VALUE_W-1:0] >> TABLE_BITS;
    assign stride   = key_high[TABLE_BITS-1:0] | TABLE_BITS'(1);

    assign slot_used  = rd_data_reg[HASH_W];
    assign slot_hit   = insert_reg ? (rd_data_reg[HASH_W-1:0] == key_reg)
                                   : (rd_data_reg[VALUE_W-1:0] == key_reg[VALUE_W-1:0]);
    assign probe_last = (count_reg == LAST_SLOT);
    assign probe_end  = !slot_used || slot_hit || probe_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_LOOKUP)
                    begin
                        state_next = S_ISSUE;
                    end
                    else if (action != ACT_NONE && last_byte)
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hash_next   = hash_reg;
        key_next    = key_reg;
        insert_next = insert_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        slot_next   = slot_reg;
        found_next  = found_reg;
        err_next    = err_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = {1'b1, key_reg};
        busy        = (state_reg != S_IDLE);

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + TABLE_BITS'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action) inside
                        ACT_LOOKUP:
                        begin
                            key_next    = HASH_W'(query_hash);
                            insert_next = 1'b0;
                        end
                        ACT_INSERT, ACT_FIND:
                        begin
                            if (last_byte)
                            begin
                                hash_next   = FNV_BASIS;
                                insert_next = (action == ACT_INSERT);
                                key_next    = (action == ACT_INSERT) ? hash_prod
                                                : HASH_W'(hash_prod[VALUE_W-1:0]);
                            end
                            else
                            begin
                                hash_next = hash_prod;
                            end
                        end
                        default:
                        begin
                            hash_next = hash_reg;
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                rd_en      = 1'b1;
                rd_addr    = key_reg[TABLE_BITS-1:0];
                pos_next   = key_reg[TABLE_BITS-1:0];
                count_next = '0;
            end
            S_PROBE:
            begin
                if (!slot_used)
                begin
                    done_next = 1'b1;
                    found_next = 1'b0;
                    if (insert_reg)
                    begin
                        // claim the free slot
                        wr_en      = 1'b1;
                        value_next = key_reg[VALUE_W-1:0];
                        slot_next  = SLOT_W'(pos_reg);
                        err_next   = ERR_OK;
                    end
                    else
                    begin
                        value_next = '0;
                        slot_next  = '0;
                        err_next   = ERR_UNKNOWN;
                    end
                end
                else if (slot_hit)
                begin
                    done_next  = 1'b1;
                    value_next = key_reg[VALUE_W-1:0];
                    slot_next  = SLOT_W'(pos_reg);
                    found_next = 1'b1;
                    err_next   = ERR_OK;
                end
                else if (probe_last)
                begin
                    done_next  = 1'b1;
                    value_next = insert_reg ? key_reg[VALUE_W-1:0] : '0;
                    slot_next  = '0;
                    found_next = 1'b0;
                    err_next   = ERR_FULL;
                end
                else
                begin
                    // advance by the odd stride and fetch the next slot
                    pos_next   = pos_reg + stride;
                    rd_en      = 1'b1;
                    rd_addr    = pos_reg + stride;
                    count_next = count_reg + TABLE_BITS'(1);
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            hash_reg  <= FNV_BASIS;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        insert_reg <= insert_next;
        pos_reg    <= pos_next;
        count_reg  <= count_next;
        value_reg  <= value_next;
        slot_reg   <= slot_next;
        found_reg  <= found_next;
        err_reg    <= err_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done         = done_reg;
    assign symbol_value = value_reg;
    assign slot         = slot_reg;
    assign found        = found_reg;
    assign error_code   = err_reg;

`ifndef ASSERT_OFF
    a_done_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_PROBE)
        else $error("result without a finished probe");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> error_code == ERR_OK)
        else $error("hit reported with an error code");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && error_code == ERR_UNKNOWN |-> symbol_value == '0 && slot == '0 && !found)
        else $error("miss result not zeroed");

    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && state_reg == S_PROBE |-> insert_reg && !slot_used)
        else $error("table write over a used slot");
`endif

endmodule

`default_nettype wire
